// ===== design/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and widths for the point-in-triangle test
// Request and result structs plus the derived datapath widths.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // coordinate width of every vertex and probe component
    localparam int COORD_WIDTH = 16;

    // edge / offset component: difference of two coordinates
    localparam int DIFF_W = COORD_WIDTH + 1;
    // product of two components
    localparam int PROD_W = 2 * DIFF_W;
    // sum of three products (dot product)
    localparam int DOT_W  = PROD_W + 2;
    // product of two dot products
    localparam int WIDE_W = 2 * DOT_W;
    // numerators, denominator and their sums
    localparam int RES_W  = WIDE_W + 2;

    // number of register stages from request to result
    localparam int NUM_STAGES = 8;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vert0_x;
        logic signed [COORD_WIDTH-1:0] vert0_y;
        logic signed [COORD_WIDTH-1:0] vert0_z;
        logic signed [COORD_WIDTH-1:0] vert1_x;
        logic signed [COORD_WIDTH-1:0] vert1_y;
        logic signed [COORD_WIDTH-1:0] vert1_z;
        logic signed [COORD_WIDTH-1:0] vert2_x;
        logic signed [COORD_WIDTH-1:0] vert2_y;
        logic signed [COORD_WIDTH-1:0] vert2_z;
        logic signed [COORD_WIDTH-1:0] probe_x;
        logic signed [COORD_WIDTH-1:0] probe_y;
        logic signed [COORD_WIDTH-1:0] probe_z;
    } query_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } verdict_t;

endpackage

// ===== design/ptt_mul.sv =====
// ----------------------------------------------------------------------------
// ptt_mul: three-stage signed multiplier
// Splits each operand into halves; partial products, then middle-term sum,
// then final recombination, each behind a register.
// ----------------------------------------------------------------------------
module ptt_mul #(
    parameter int OP_WIDTH = 36
) (
    input  logic                           clk,
    input  logic [2:0]                     en,
    input  logic signed [OP_WIDTH-1:0]     a,
    input  logic signed [OP_WIDTH-1:0]     b,
    output logic signed [2*OP_WIDTH-1:0]   p
);

    localparam int HALF  = (OP_WIDTH + 1) / 2;
    localparam int HI_W  = OP_WIDTH - HALF;
    localparam int HH_W  = 2 * HI_W;
    localparam int LL_W  = 2 * HALF;
    localparam int X_W   = HI_W + HALF + 1;
    localparam int MID_W = X_W + 1;
    localparam int P_W   = 2 * OP_WIDTH;

    logic signed [HI_W-1:0]  a_hi, b_hi;
    logic signed [HALF:0]    a_lo, b_lo;

    logic signed [HH_W-1:0]  pp_hh_reg;
    logic        [LL_W-1:0]  pp_ll_reg;
    logic signed [X_W-1:0]   pp_hl_reg, pp_lh_reg;

    logic signed [P_W-1:0]   cat_reg;
    logic signed [MID_W-1:0] mid_reg;
    logic signed [P_W-1:0]   mid_wide;

    logic signed [P_W-1:0]   p_reg;

    // high half signed, low half zero-extended
    assign a_hi = $signed(a[OP_WIDTH-1:HALF]);
    assign b_hi = $signed(b[OP_WIDTH-1:HALF]);
    assign a_lo = $signed({1'b0, a[HALF-1:0]});
    assign b_lo = $signed({1'b0, b[HALF-1:0]});

    assign mid_wide = {{(P_W-MID_W){mid_reg[MID_W-1]}}, mid_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_hh_reg <= HH_W'(a_hi) * HH_W'(b_hi);
            pp_ll_reg <= LL_W'(a[HALF-1:0]) * LL_W'(b[HALF-1:0]);
            pp_hl_reg <= X_W'(a_hi) * X_W'(b_lo);
            pp_lh_reg <= X_W'(a_lo) * X_W'(b_hi);
        end
        if (en[1])
        begin
            // low partial is below 2^(2*HALF), so it concatenates exactly
            cat_reg <= $signed({pp_hh_reg, pp_ll_reg});
            mid_reg <= MID_W'(pp_hl_reg) + MID_W'(pp_lh_reg);
        end
        if (en[2])
        begin
            p_reg <= cat_reg + (mid_wide <<< HALF);
        end
    end

    assign p = p_reg;

endmodule

// ===== design/point_in_triangle_test.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test: barycentric point-in-triangle test
// Exact integer pipeline: edges, dot products, numerators, verdict.
// ----------------------------------------------------------------------------
// Usage:
//   query channel: one request holds three vertices and a probe point, all
//   signed COORD_WIDTH-bit coordinates. Taken when query_valid is high and
//   query_stall is low.
//   verdict channel: one result per request, in order: inside_res and
//   degenerate. Taken when verdict_valid is high and verdict_stall is low.
// Throughput: one request per cycle, sustained while verdict_stall stays low.
// Pipeline: each request passes through the eight register stages
//   (differences, products, dot sums, three stages of the split wide
//   multiplier, subtracts, compare) before its verdict_valid rises.
// Stall: a stage holds while it is full and the one after it holds, so
//   bubbles close up; query_stall rises only when all stages are full and
//   the receiver stalls. Nothing is lost or repeated.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty
//   and ready to take a request in the first cycle.
// A degenerate (zero-area) triangle reports degenerate = 1, inside_res = 0.
// A probe off the plane is judged by its projection onto the plane.
// ----------------------------------------------------------------------------
module point_in_triangle_test (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_stall,
    input  ptt_pkg::query_t   query,
    output logic              verdict_valid,
    input  logic              verdict_stall,
    output ptt_pkg::verdict_t verdict
);

    localparam int DIFF_W = ptt_pkg::DIFF_W;
    localparam int PROD_W = ptt_pkg::PROD_W;
    localparam int DOT_W  = ptt_pkg::DOT_W;
    localparam int WIDE_W = ptt_pkg::WIDE_W;
    localparam int RES_W  = ptt_pkg::RES_W;
    localparam int NS     = ptt_pkg::NUM_STAGES;

    // stage valid bits and per-stage load enables
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // stage 1: edge vectors e0 = v2 - v0, e1 = v1 - v0, offset p = q - v0
    logic signed [DIFF_W-1:0] e0_reg [3];
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] pv_reg [3];
    logic signed [DIFF_W-1:0] e0_next [3];
    logic signed [DIFF_W-1:0] e1_next [3];
    logic signed [DIFF_W-1:0] pv_next [3];

    // stage 2: component products of the five dot products
    logic signed [PROD_W-1:0] m00_reg [3];
    logic signed [PROD_W-1:0] m01_reg [3];
    logic signed [PROD_W-1:0] m02_reg [3];
    logic signed [PROD_W-1:0] m11_reg [3];
    logic signed [PROD_W-1:0] m12_reg [3];

    // stage 3: dot products
    logic signed [DOT_W-1:0] d00_reg, d01_reg, d02_reg, d11_reg, d12_reg;

    // stages 4..6: six wide products inside the multipliers
    logic signed [WIDE_W-1:0] p_d00_d11, p_d01_d01, p_d11_d02;
    logic signed [WIDE_W-1:0] p_d01_d12, p_d00_d12, p_d01_d02;

    // stage 7: denominator and numerators
    logic signed [RES_W-1:0] den_reg, un_reg, vn_reg;

    // stage 8: result register
    ptt_pkg::verdict_t verdict_reg;
    ptt_pkg::verdict_t verdict_next;
    logic signed [RES_W-1:0] uv_sum;
    logic                    degen;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the next one moves.
    // ------------------------------------------------------------------
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !verdict_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = query_valid;
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign query_stall = !en[0];

    // ------------------------------------------------------------------
    // Stage 1: differences against vertex 0
    // ------------------------------------------------------------------
    always_comb
    begin
        e0_next[0] = DIFF_W'($signed(query.vert2_x)) - DIFF_W'($signed(query.vert0_x));
        e0_next[1] = DIFF_W'($signed(query.vert2_y)) - DIFF_W'($signed(query.vert0_y));
        e0_next[2] = DIFF_W'($signed(query.vert2_z)) - DIFF_W'($signed(query.vert0_z));
        e1_next[0] = DIFF_W'($signed(query.vert1_x)) - DIFF_W'($signed(query.vert0_x));
        e1_next[1] = DIFF_W'($signed(query.vert1_y)) - DIFF_W'($signed(query.vert0_y));
        e1_next[2] = DIFF_W'($signed(query.vert1_z)) - DIFF_W'($signed(query.vert0_z));
        pv_next[0] = DIFF_W'($signed(query.probe_x)) - DIFF_W'($signed(query.vert0_x));
        pv_next[1] = DIFF_W'($signed(query.probe_y)) - DIFF_W'($signed(query.vert0_y));
        pv_next[2] = DIFF_W'($signed(query.probe_z)) - DIFF_W'($signed(query.vert0_z));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k] <= e0_next[k];
                e1_reg[k] <= e1_next[k];
                pv_reg[k] <= pv_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-component products
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                m00_reg[k] <= PROD_W'(e0_reg[k]) * PROD_W'(e0_reg[k]);
                m01_reg[k] <= PROD_W'(e0_reg[k]) * PROD_W'(e1_reg[k]);
                m02_reg[k] <= PROD_W'(e0_reg[k]) * PROD_W'(pv_reg[k]);
                m11_reg[k] <= PROD_W'(e1_reg[k]) * PROD_W'(e1_reg[k]);
                m12_reg[k] <= PROD_W'(e1_reg[k]) * PROD_W'(pv_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dot products (three-term sums)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            d00_reg <= DOT_W'(m00_reg[0]) + DOT_W'(m00_reg[1]) + DOT_W'(m00_reg[2]);
            d01_reg <= DOT_W'(m01_reg[0]) + DOT_W'(m01_reg[1]) + DOT_W'(m01_reg[2]);
            d02_reg <= DOT_W'(m02_reg[0]) + DOT_W'(m02_reg[1]) + DOT_W'(m02_reg[2]);
            d11_reg <= DOT_W'(m11_reg[0]) + DOT_W'(m11_reg[1]) + DOT_W'(m11_reg[2]);
            d12_reg <= DOT_W'(m12_reg[0]) + DOT_W'(m12_reg[1]) + DOT_W'(m12_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stages 4..6: wide products of dot products
    // ------------------------------------------------------------------
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_den_a (
        .clk (clk), .en (en[5:3]), .a (d00_reg), .b (d11_reg), .p (p_d00_d11)
    );
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_den_b (
        .clk (clk), .en (en[5:3]), .a (d01_reg), .b (d01_reg), .p (p_d01_d01)
    );
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_u_a (
        .clk (clk), .en (en[5:3]), .a (d11_reg), .b (d02_reg), .p (p_d11_d02)
    );
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_u_b (
        .clk (clk), .en (en[5:3]), .a (d01_reg), .b (d12_reg), .p (p_d01_d12)
    );
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_v_a (
        .clk (clk), .en (en[5:3]), .a (d00_reg), .b (d12_reg), .p (p_d00_d12)
    );
    ptt_mul #(.OP_WIDTH(DOT_W)) u_mul_v_b (
        .clk (clk), .en (en[5:3]), .a (d01_reg), .b (d02_reg), .p (p_d01_d02)
    );

    // ------------------------------------------------------------------
    // Stage 7: denom = d00*d11 - d01^2, u = d11*d02 - d01*d12,
    //          v = d00*d12 - d01*d02
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            den_reg <= RES_W'(p_d00_d11) - RES_W'(p_d01_d01);
            un_reg  <= RES_W'(p_d11_d02) - RES_W'(p_d01_d12);
            vn_reg  <= RES_W'(p_d00_d12) - RES_W'(p_d01_d02);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: verdict. Inside needs denom > 0, u >= 0, v >= 0, u+v < denom.
    // ------------------------------------------------------------------
    always_comb
    begin
        uv_sum = un_reg + vn_reg;
        degen  = den_reg[RES_W-1] || (den_reg == '0);
        verdict_next.degenerate = degen;
        verdict_next.inside_res = !degen && !un_reg[RES_W-1] && !vn_reg[RES_W-1]
                                  && (uv_sum < den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict_valid = valid_reg[NS-1];
    assign verdict       = verdict_reg;

endmodule

// ===== verif/ptt_verdict_ledger_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_verdict_ledger_pkg: verdict predictor and in-order checker
// Works out each expected verdict exactly in integers, keeps the pending
// verdicts in request order and compares each one that the block returns.
// ----------------------------------------------------------------------------
package ptt_verdict_ledger_pkg;

    // wide enough for every barycentric term without overflow
    typedef logic signed [127:0] big_t;

    class verdict_ledger;

        typedef struct {
            ptt_pkg::query_t   q;
            ptt_pkg::verdict_t v;
            int unsigned       tag;
        } awaited_t;

        awaited_t    awaited[$];
        int unsigned queries;
        int unsigned verdicts;
        int unsigned errors;
        int unsigned inside_cnt;
        int unsigned degen_cnt;

        // exact barycentric test on the projected probe
        function ptt_pkg::verdict_t judge_probe(ptt_pkg::query_t q);
            longint            e0[3];
            longint            e1[3];
            longint            pv[3];
            longint            d00, d01, d02, d11, d12;
            big_t              den, un, vn;
            ptt_pkg::verdict_t r;
            e0[0] = longint'(q.vert2_x) - longint'(q.vert0_x);
            e0[1] = longint'(q.vert2_y) - longint'(q.vert0_y);
            e0[2] = longint'(q.vert2_z) - longint'(q.vert0_z);
            e1[0] = longint'(q.vert1_x) - longint'(q.vert0_x);
            e1[1] = longint'(q.vert1_y) - longint'(q.vert0_y);
            e1[2] = longint'(q.vert1_z) - longint'(q.vert0_z);
            pv[0] = longint'(q.probe_x) - longint'(q.vert0_x);
            pv[1] = longint'(q.probe_y) - longint'(q.vert0_y);
            pv[2] = longint'(q.probe_z) - longint'(q.vert0_z);
            d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
            d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
            d02 = e0[0] * pv[0] + e0[1] * pv[1] + e0[2] * pv[2];
            d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
            d12 = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
            den = big_t'(d00) * big_t'(d11) - big_t'(d01) * big_t'(d01);
            un  = big_t'(d11) * big_t'(d02) - big_t'(d01) * big_t'(d12);
            vn  = big_t'(d00) * big_t'(d12) - big_t'(d01) * big_t'(d02);
            r.degenerate = (den <= 0);
            r.inside_res = !r.degenerate && (un >= 0) && (vn >= 0) && (un + vn < den);
            return r;
        endfunction

        function void note_query(ptt_pkg::query_t q);
            awaited_t a;
            a.q   = q;
            a.v   = judge_probe(q);
            a.tag = queries;
            queries++;
            if (a.v.inside_res)
                inside_cnt++;
            if (a.v.degenerate)
                degen_cnt++;
            awaited.push_back(a);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_verdict(ptt_pkg::verdict_t got);
            awaited_t a;
            verdicts++;
            if (awaited.size() == 0)
            begin
                report($sformatf("verdict %0d arrived with no request pending", verdicts));
                return;
            end
            a = awaited.pop_front();
            if (got.inside_res !== a.v.inside_res)
                report($sformatf("request %0d inside_res: got %b, want %b (query %h)",
                                 a.tag, got.inside_res, a.v.inside_res, a.q));
            if (got.degenerate !== a.v.degenerate)
                report($sformatf("request %0d degenerate: got %b, want %b (query %h)",
                                 a.tag, got.degenerate, a.v.degenerate, a.q));
        endtask

        function int pending();
            return awaited.size();
        endfunction

    endclass

endpackage

// ===== verif/tb_point_in_triangle_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_triangle_test: testbench for the point-in-triangle test
// Drives directed and random triangle/probe requests with bursty sender
// gaps and a patterned receiver stall, predicts every verdict exactly and
// checks the results in order.
// ----------------------------------------------------------------------------
module tb_point_in_triangle_test;

    localparam int CW          = ptt_pkg::COORD_WIDTH;
    localparam int CMAX        = 2 ** (CW - 1) - 1;
    localparam int CMIN        = -(2 ** (CW - 1));
    localparam int HOLD_CYCLES = 80;   // long receiver hold-off, well past pipe depth
    localparam int RANDOM_REQS = 2000;

    // receiver stall patterns
    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    // vertices 0..2 then the probe, each x/y/z
    typedef int point_set_t [4][3];

    logic              clk;
    logic              rst_n;
    logic              query_valid;
    logic              query_stall;
    ptt_pkg::query_t   query;
    logic              verdict_valid;
    logic              verdict_stall;
    ptt_pkg::verdict_t verdict;

    ptt_verdict_ledger_pkg::verdict_ledger ledger = new;

    bit          hold_req;        // set by the sender side, cleared by the stall process
    int unsigned burst_left;
    int unsigned backpressure_cycles;

    point_in_triangle_test dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_valid   (query_valid),
        .query_stall   (query_stall),
        .query         (query),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Hard stop. A run that reaches it is reported as failed.
    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample both handshakes at the rising edge. A request is
    // recorded when it is taken, a verdict checked when it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (query_valid && !query_stall)
                ledger.note_query(query);
            if (query_valid && query_stall)
                backpressure_cycles++;
            if (verdict_valid && !verdict_stall)
                ledger.check_verdict(verdict);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern redrawn at random as each one runs out. When
    // the sender side raises hold_req the stall is held high through a hold-off,
    // counted here, so the pipe fills and pushes back on the request side.
    // ------------------------------------------------------------------------
    initial
    begin
        flow_mode_t  mode;
        int unsigned mode_left;
        int unsigned phase;
        verdict_stall = 1'b0;
        mode          = FLOW_FREE;
        mode_left     = 0;
        phase         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                verdict_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = flow_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            phase++;
            case (mode)
                FLOW_FREE:     verdict_stall <= 1'b0;
                FLOW_LIGHT:    verdict_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY:    verdict_stall <= ($urandom_range(0, 9) < 6);
                FLOW_PERIODIC: verdict_stall <= ((phase % 5) < 3);
                default:       verdict_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int clip_int(int v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    // uniform in [-span, span]
    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 6))
            0:       return CMIN;
            1:       return CMIN + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return CMAX - 1;
            default: return CMAX;
        endcase
    endfunction

    function automatic ptt_pkg::query_t pack_query(point_set_t ps);
        ptt_pkg::query_t q;
        q.vert0_x = CW'(clip_int(ps[0][0]));
        q.vert0_y = CW'(clip_int(ps[0][1]));
        q.vert0_z = CW'(clip_int(ps[0][2]));
        q.vert1_x = CW'(clip_int(ps[1][0]));
        q.vert1_y = CW'(clip_int(ps[1][1]));
        q.vert1_z = CW'(clip_int(ps[1][2]));
        q.vert2_x = CW'(clip_int(ps[2][0]));
        q.vert2_y = CW'(clip_int(ps[2][1]));
        q.vert2_z = CW'(clip_int(ps[2][2]));
        q.probe_x = CW'(clip_int(ps[3][0]));
        q.probe_y = CW'(clip_int(ps[3][1]));
        q.probe_z = CW'(clip_int(ps[3][2]));
        return q;
    endfunction

    // Random request. Half are built triangles, most with a probe placed by
    // barycentric weights (inside, on an edge, or pushed off the plane) and
    // some with the probe loosely around it; the rest are collinear sets, tiny
    // clustered sets, extreme corners and fully random noise.
    function automatic ptt_pkg::query_t make_random_query();
        point_set_t ps;
        int         base[3];
        int         dir[3];
        int         w[3];
        int         wsum;
        int         span;
        int         k1, k2;
        int         sel;
        sel  = $urandom_range(0, 99);
        span = 1 << $urandom_range(2, 14);
        for (int k = 0; k < 3; k++)
        begin
            base[k] = srand(CMAX);
            dir[k]  = srand(100);
        end
        if (sel < 40)
        begin
            // probe as a weighted mix of the vertices
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                    ps[j][k] = clip_int(base[k] + srand(span));
                w[j] = $urandom_range(0, 40);
            end
            if ($urandom_range(0, 9) == 0)
                w[$urandom_range(0, 2)] = 0;
            wsum = w[0] + w[1] + w[2];
            if (wsum == 0)
            begin
                w[0] = 1;
                wsum = 1;
            end
            for (int k = 0; k < 3; k++)
            begin
                ps[3][k] = (w[0] * ps[0][k] + w[1] * ps[1][k] + w[2] * ps[2][k]) / wsum;
                if ($urandom_range(0, 2) == 0)
                    ps[3][k] += srand(span);
            end
        end
        else if (sel < 50)
        begin
            // collinear or coincident vertices
            k1 = srand(50);
            k2 = srand(50);
            for (int k = 0; k < 3; k++)
            begin
                base[k]  = srand(16000);
                ps[0][k] = base[k];
                ps[1][k] = base[k] + k1 * dir[k];
                ps[2][k] = base[k] + k2 * dir[k];
                ps[3][k] = srand(CMAX);
            end
        end
        else if (sel < 65)
        begin
            // tiny cluster somewhere in the space
            for (int k = 0; k < 3; k++)
            begin
                base[k] = srand(30000);
                for (int j = 0; j < 4; j++)
                    ps[j][k] = base[k] + srand(3);
            end
        end
        else if (sel < 75)
        begin
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 3; k++)
                    ps[j][k] = extreme_coord();
        end
        else if (sel < 85)
        begin
            // built triangle, probe loosely around it
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                    ps[j][k] = clip_int(base[k] + srand(span));
                ps[3][k] = base[k] + srand(2 * span);
            end
        end
        else
        begin
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 3; k++)
                    ps[j][k] = int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
        end
        return pack_query(ps);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after
    // the request was taken. Requests go out in bursts with idle gaps
    // between them; no gaps while a receiver hold-off is in progress so the
    // pipe is sure to back up.
    // ------------------------------------------------------------------------
    task automatic send_item(ptt_pkg::query_t q);
        int unsigned gap;
        if (burst_left == 0 && !hold_req)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                query_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic offer_points(point_set_t ps);
        send_item(pack_query(ps));
    endtask

    // sender goes quiet until every pending verdict is back
    task automatic drain_pending();
        query_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        ptt_pkg::query_t q;
        rst_n       = 1'b0;
        query_valid = 1'b0;
        query       = '0;
        hold_req    = 1'b0;
        burst_left  = 0;
        backpressure_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: right triangle in the xy plane, e1 along x, e0 along y
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 0}});
        // same point far off the plane: judged by its projection
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 32767}});
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, -32768}});
        // beyond the hypotenuse, on the hypotenuse, left of the y edge
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{60, 60, 0}});
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, 50, 0}});
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{-1, 5, 0}});
        // on each edge through vertex 0
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{0, 50, 0}});
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, 0, 0}});
        // small triangle, probe at an extreme corner
        offer_points('{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{32767, -32768, 32767}});
        // big triangles: probe on each vertex (only vertex 0 inside), one at the origin
        offer_points('{'{-32768, -32768, -32768}, '{32767, -32768, -32768},
                       '{-32768, 32767, 32767}, '{-32768, -32768, -32768}});
        offer_points('{'{-32768, -32768, -32768}, '{32767, -32768, -32768},
                       '{-32768, 32767, 32767}, '{32767, -32768, -32768}});
        offer_points('{'{-32768, -32768, -32768}, '{32767, -32768, -32768},
                       '{-32768, 32767, 32767}, '{-32768, 32767, 32767}});
        offer_points('{'{32767, 32767, -32768}, '{-32768, 32767, 32767},
                       '{32767, -32768, 32767}, '{0, 0, 0}});
        // zero-area triangles: all zero, all minimum, all maximum, collinear,
        // two vertices coincident at the extremes
        offer_points('{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}});
        offer_points('{'{-32768, -32768, -32768}, '{-32768, -32768, -32768},
                       '{-32768, -32768, -32768}, '{-32768, -32768, -32768}});
        offer_points('{'{32767, 32767, 32767}, '{32767, 32767, 32767},
                       '{32767, 32767, 32767}, '{32767, 32767, 32767}});
        offer_points('{'{0, 0, 0}, '{1, 2, 3}, '{2, 4, 6}, '{1, 2, 3}});
        offer_points('{'{-32768, -32768, -32768}, '{32767, 32767, 32767},
                       '{-32768, -32768, -32768}, '{5, -7, 9}});
        drain_pending();

        // Random requests, with two long receiver hold-offs and one pause
        // of the sender until the pipe has drained.
        for (int unsigned i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == 500 || i == 1500)
                hold_req = 1'b1;
            if (i == 1000)
                drain_pending();
            q = make_random_query();
            send_item(q);
        end

        // wait for the tail, then longer than the pipe is deep to catch stray verdicts
        query_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        repeat (ptt_pkg::NUM_STAGES + 4) @(negedge clk);

        $display("Run covered %0d requests: %0d inside, %0d degenerate, %0d outside.",
                 ledger.queries, ledger.inside_cnt, ledger.degen_cnt,
                 ledger.queries - ledger.inside_cnt - ledger.degen_cnt);
        $display("Request side was held off for %0d cycles; %0d mismatches found.",
                 backpressure_cycles, ledger.errors);
        if (ledger.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
